// ===== hw/rtl/bsm_pkg.sv =====
package bsm_pkg;

   localparam int CW   = 32;          // coordinate width
   localparam int RW   = CW - 1;      // radius width
   localparam int MW   = CW + 1;      // magnitude of a center difference
   localparam int SQW  = 2 * MW;      // square and sum of squares
   localparam int RTW  = SQW / 2;     // square root (center distance)
   localparam int SRW  = RTW + 4;     // square root partial remainder
   localparam int NW   = RW + MW;     // offset numerator
   localparam int QW   = CW;          // offset quotient
   localparam int DRW  = RTW + 1;     // divider partial remainder
   localparam int SW   = CW + 3;      // center sum before halving
   localparam int TDIN = 256;         // request tdata width
   localparam int TDOUT = 128;        // response tdata width

   typedef enum logic [1:0] {
      CASE_FIRST  = 2'd0,
      CASE_SECOND = 2'd1,
      CASE_NEW    = 2'd2
   } merge_case_type;

   typedef struct packed {
      logic [2:0][CW-1:0] a;
      logic [2:0][CW-1:0] b;
      logic [RW-1:0]      ra;
      logic [RW-1:0]      rb;
      logic [2:0][MW-1:0] zmag;
      logic [2:0]         zneg;
   } pair_type;

   typedef struct packed {
      pair_type       p;
      logic [SQW-1:0] rad;
      logic [SRW-1:0] rem;
      logic [RTW-1:0] root;
   } sqrt_item_type;

   typedef struct packed {
      pair_type            p;
      logic [RTW-1:0]      cdist;
      merge_case_type      mcase;
      logic                dneg;
      logic [2:0][QW-1:0]  numlo;
      logic [2:0][DRW-1:0] rem;
      logic [2:0][QW-1:0]  quo;
   } div_item_type;

endpackage

// ===== hw/rtl/bsm_sqrt_cell.sv =====
module bsm_sqrt_cell import bsm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  sqrt_item_type in_item,
   output logic          out_valid,
   output sqrt_item_type out_item
);

   logic          valid_ff;
   sqrt_item_type item_ff;
   sqrt_item_type item_in;
   logic [SRW-1:0] shifted;
   logic [SRW-1:0] trial;

   // One root bit per cell: bring down two radicand bits, try root*4+1.
   always_comb begin
      item_in = in_item;
      shifted = {in_item.rem[SRW-3:0], in_item.rad[SQW-1 -: 2]};
      trial   = {{(SRW-RTW-2){1'b0}}, in_item.root, 2'b01};
      item_in.rad = {in_item.rad[SQW-3:0], 2'b00};
      if (shifted >= trial) begin
         item_in.rem  = shifted - trial;
         item_in.root = {in_item.root[RTW-2:0], 1'b1};
      end else begin
         item_in.rem  = shifted;
         item_in.root = {in_item.root[RTW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== hw/rtl/bsm_div_cell.sv =====
module bsm_div_cell import bsm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  div_item_type in_item,
   output logic         out_valid,
   output div_item_type out_item
);

   logic         valid_ff;
   div_item_type item_ff;
   div_item_type item_in;
   logic [2:0][DRW-1:0] shifted;
   logic [DRW-1:0]      divisor;

   // One quotient bit per cell for each of the three axes; the divisor is shared.
   always_comb begin
      item_in = in_item;
      divisor = {1'b0, in_item.cdist};
      for (int k = 0; k < 3; k++) begin
         shifted[k] = {in_item.rem[k][DRW-2:0], in_item.numlo[k][QW-1]};
         item_in.numlo[k] = {in_item.numlo[k][QW-2:0], 1'b0};
         if (shifted[k] >= divisor) begin
            item_in.rem[k] = shifted[k] - divisor;
            item_in.quo[k] = {in_item.quo[k][QW-2:0], 1'b1};
         end else begin
            item_in.rem[k] = shifted[k];
            item_in.quo[k] = {in_item.quo[k][QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== hw/rtl/bounding_sphere_merge.sv =====
// Pipeline: square, sum, 33 square root cells, decision, 32 divider cells,
// output register.
// Throughput: one sphere pair per cycle; the whole cell chain advances together
// and holds while a response waits and rsp_tready is low.
// Reset: synchronous, active high; clears every valid bit in the chain.
module bounding_sphere_merge import bsm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // first_x, first_y, first_z, first_radius, second_x, second_y, second_z,
   // second_radius
   input  logic [TDIN-1:0]  req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // merged_x, merged_y, merged_z, merged_radius
   output logic [TDOUT-1:0] rsp_tdata,
   // merge_case
   output logic [1:0]       rsp_tuser
);

   logic advance;

   // Front: differences and squares.
   pair_type            pair_in;
   logic [2:0][MW-1:0]  diff;
   logic [2:0][SQW-1:0] sq_in;
   logic                a_valid_ff;
   pair_type            a_pair_ff;
   logic [2:0][SQW-1:0] a_sq_ff;
   logic                b_valid_ff;
   sqrt_item_type       b_item_ff;
   sqrt_item_type       b_item_in;

   sqrt_item_type sq_item  [RTW+1];
   logic          sq_valid [RTW+1];
   div_item_type  dv_item  [QW+1];
   logic          dv_valid [QW+1];

   div_item_type        dv_in;
   logic [RTW-1:0]      cdist;
   logic signed [CW-1:0] dr;
   logic [RW-1:0]       drmag;
   logic [2:0][NW-1:0]  num;
   logic                dv_valid_ff;
   div_item_type        dv_item_ff;

   // Back: centers and radius.
   div_item_type        fin;
   logic [2:0][SW-1:0]  tq;
   logic [2:0][SW-1:0]  tsg;
   logic [2:0][SW-1:0]  csum;
   logic [2:0][SW-1:0]  chalf;
   logic [2:0][SW-1:0]  cshift;
   logic [2:0][CW-1:0]  cnew;
   logic [RTW:0]        rsum;
   logic [RTW-1:0]      rhalf;
   logic [RW-1:0]       rnew;
   logic [2:0][CW-1:0]  cout;
   logic [RW-1:0]       rout;
   logic                rsp_valid_ff;
   logic [TDOUT-1:0]    rsp_data_ff;
   logic [TDOUT-1:0]    rsp_data_in;
   logic [1:0]          rsp_user_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      pair_in.a[0] = req_tdata[31:0];
      pair_in.a[1] = req_tdata[63:32];
      pair_in.a[2] = req_tdata[95:64];
      pair_in.ra   = req_tdata[126:96];
      pair_in.b[0] = req_tdata[158:127];
      pair_in.b[1] = req_tdata[190:159];
      pair_in.b[2] = req_tdata[222:191];
      pair_in.rb   = req_tdata[253:223];
      for (int k = 0; k < 3; k++) begin
         diff[k] = {pair_in.a[k][CW-1], pair_in.a[k]} - {pair_in.b[k][CW-1], pair_in.b[k]};
         pair_in.zneg[k] = diff[k][MW-1];
         pair_in.zmag[k] = diff[k][MW-1] ? (~diff[k] + 1'b1) : diff[k];
         sq_in[k] = {{MW{1'b0}}, pair_in.zmag[k]} * {{MW{1'b0}}, pair_in.zmag[k]};
      end
   end

   always_comb begin
      b_item_in.p    = a_pair_ff;
      b_item_in.rad  = a_sq_ff[0] + a_sq_ff[1] + a_sq_ff[2];
      b_item_in.rem  = '0;
      b_item_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_tvalid;
         b_valid_ff <= a_valid_ff;
      end
      if (advance) begin
         a_pair_ff <= pair_in;
         a_sq_ff   <= sq_in;
         b_item_ff <= b_item_in;
      end
   end

   assign sq_item[0]  = b_item_ff;
   assign sq_valid[0] = b_valid_ff;

   for (genvar i = 0; i < RTW; i++) begin : g_sqrt
      bsm_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (sq_valid[i]),
         .in_item   (sq_item[i]),
         .out_valid (sq_valid[i+1]),
         .out_item  (sq_item[i+1])
      );
   end

   // Containment tests and the offset numerators |dr| * |z|.
   always_comb begin
      cdist = sq_item[RTW].root;
      dr = {1'b0, sq_item[RTW].p.ra} - {1'b0, sq_item[RTW].p.rb};
      drmag = dr[CW-1] ? RW'(~dr + 1'b1) : dr[RW-1:0];
      dv_in.p     = sq_item[RTW].p;
      dv_in.cdist = cdist;
      dv_in.dneg  = dr[CW-1];
      if (({1'b0, cdist} + {3'b000, sq_item[RTW].p.rb}) <= {3'b000, sq_item[RTW].p.ra}) begin
         dv_in.mcase = CASE_FIRST;
      end else if (({1'b0, cdist} + {3'b000, sq_item[RTW].p.ra})
                   <= {3'b000, sq_item[RTW].p.rb}) begin
         dv_in.mcase = CASE_SECOND;
      end else begin
         dv_in.mcase = CASE_NEW;
      end
      for (int k = 0; k < 3; k++) begin
         num[k] = {{MW{1'b0}}, drmag} * {{RW{1'b0}}, sq_item[RTW].p.zmag[k]};
         dv_in.numlo[k] = num[k][QW-1:0];
         dv_in.rem[k]   = {{(DRW-(NW-QW)){1'b0}}, num[k][NW-1:QW]};
         dv_in.quo[k]   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff <= 1'b0;
      end else if (advance) begin
         dv_valid_ff <= sq_valid[RTW];
      end
      if (advance) begin
         dv_item_ff <= dv_in;
      end
   end

   assign dv_item[0]  = dv_item_ff;
   assign dv_valid[0] = dv_valid_ff;

   for (genvar i = 0; i < QW; i++) begin : g_div
      bsm_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (dv_valid[i]),
         .in_item   (dv_item[i]),
         .out_valid (dv_valid[i+1]),
         .out_item  (dv_item[i+1])
      );
   end

   // New center: (a + b + t) / 2 truncated toward zero, then saturated.
   always_comb begin
      fin = dv_item[QW];
      for (int k = 0; k < 3; k++) begin
         tq[k]  = {{(SW-QW){1'b0}}, fin.quo[k]};
         tsg[k] = (fin.dneg ^ fin.p.zneg[k]) ? (~tq[k] + 1'b1) : tq[k];
         csum[k] = {{(SW-CW){fin.p.a[k][CW-1]}}, fin.p.a[k]}
                 + {{(SW-CW){fin.p.b[k][CW-1]}}, fin.p.b[k]} + tsg[k];
         chalf[k]  = csum[k] + {{(SW-1){1'b0}}, csum[k][SW-1]};
         cshift[k] = {chalf[k][SW-1], chalf[k][SW-1:1]};
         if ((&cshift[k][SW-1:CW-1]) || !(|cshift[k][SW-1:CW-1])) begin
            cnew[k] = cshift[k][CW-1:0];
         end else if (cshift[k][SW-1]) begin
            cnew[k] = {1'b1, {(CW-1){1'b0}}};
         end else begin
            cnew[k] = {1'b0, {(CW-1){1'b1}}};
         end
      end
      rsum  = {3'b000, fin.p.ra} + {3'b000, fin.p.rb} + {1'b0, fin.cdist};
      rhalf = rsum[RTW:1];
      rnew  = (|rhalf[RTW-1:RW]) ? {RW{1'b1}} : rhalf[RW-1:0];
      unique case (fin.mcase)
         CASE_FIRST: begin
            cout = fin.p.a;
            rout = fin.p.ra;
         end
         CASE_SECOND: begin
            cout = fin.p.b;
            rout = fin.p.rb;
         end
         default: begin
            cout = cnew;
            rout = rnew;
         end
      endcase
      rsp_data_in = {1'b0, rout, cout[2], cout[1], cout[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid[QW];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= fin.mcase;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
